/* src/assert_macros.svh */
// Assertion macros shared by the lap timer modules.
// Included by every module that checks its own logic; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define LTFD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds at every edge, reset included.
`define LTFD_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ltfd_pkg.sv */
// Shared types and constants of the lap timer finish line detector.
// Used by the front, queue, back and top level modules; depends on nothing.
package ltfd_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Classified word that travels from the front to the back.
	typedef struct packed {
		op_t  op;
		logic line;
	} item_t;

	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_LEAVE_CONFIRM  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FINISH_CONFIRM = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LAP        = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD      = 8'd3;

	localparam logic [7:0]  LEAVE_CONFIRM_RESET  = 8'd10;
	localparam logic [7:0]  FINISH_CONFIRM_RESET = 8'd3;
	localparam logic [15:0] MIN_LAP_RESET        = 16'd1800;
	localparam logic [2:0]  THRESHOLD_RESET      = 3'd2;

	typedef struct packed {
		logic [7:0]  leave_confirm;
		logic [7:0]  finish_confirm;
		logic [15:0] min_lap;
		logic [2:0]  threshold;
	} cfg_t;

	localparam int unsigned QUEUE_DEPTH = 2;

endpackage

/* src/ltfd_front.sv */
// Front end: accepts command words and classifies them for the back end.
// Depends on ltfd_pkg for the operation codes and the classified word type.
module ltfd_front #(
	parameter int unsigned SENSOR_COUNT = 5
) (
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              command,
	input  logic [SENSOR_COUNT-1:0] line_sensors,
	input  logic [2:0]              threshold,
	input  logic                    q_full,
	output logic                    q_push,
	output ltfd_pkg::item_t         q_item
);
	import ltfd_pkg::*;

	localparam int unsigned CW   = $clog2(SENSOR_COUNT + 1);
	localparam int unsigned CMPW = (CW > 3) ? CW : 3;

	logic [CW-1:0] set_count;
	op_t           op;

	always_comb begin
		set_count = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			set_count = set_count + CW'(line_sensors[i]);
		end
	end

	always_comb begin
		case (command)
			OP_TICK:  op = OP_TICK;
			OP_START: op = OP_START;
			OP_STOP:  op = OP_STOP;
			default:  op = OP_NONE;
		endcase
	end

	assign in_ready     = !q_full;
	assign q_push       = in_valid && in_ready;
	assign q_item.op    = op;
	assign q_item.line  = CMPW'(set_count) >= CMPW'(threshold);

endmodule

/* src/ltfd_queue.sv */
// Short queue of classified words between the front and the back end.
// Depends on ltfd_pkg for the word type and depth; uses assert_macros.svh.
`include "assert_macros.svh"

module ltfd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ltfd_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output ltfd_pkg::item_t head_item
);
	import ltfd_pkg::*;

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

	item_t         mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full      = count_q == NW'(QUEUE_DEPTH);
	assign nonempty  = count_q != '0;
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`LTFD_ASSERT(a_no_pop_empty, clk, arst_n, pop |-> nonempty, "queue popped while empty")
	`LTFD_ASSERT(a_no_push_full, clk, arst_n, push |-> !full, "queue pushed while full")
	`LTFD_ASSERT(a_count_bound, clk, arst_n, count_q <= NW'(QUEUE_DEPTH), "queue count overflow")

endmodule

/* src/ltfd_back.sv */
// Back end: applies classified words to the lap state and registers results.
// Depends on ltfd_pkg for the word and register types; uses assert_macros.svh.
`include "assert_macros.svh"

module ltfd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ltfd_pkg::cfg_t  cfg,
	input  logic            q_nonempty,
	input  ltfd_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     elapsed_ticks,
	output logic            is_running,
	output logic            is_finished,
	output logic            has_left_start,
	output logic            brake_request
);
	import ltfd_pkg::*;

	logic [31:0] tick_q, tick_nxt, tick_inc;
	logic        run_q, run_nxt;
	logic        fin_q, fin_nxt;
	logic        left_q, left_nxt;
	logic [7:0]  clr_q, clr_nxt, clr_inc;
	logic [7:0]  line_q, line_nxt, line_inc;
	logic        brake;

	logic        out_valid_q;
	logic [31:0] ticks_q;
	logic        running_q, finished_q, left_start_q, brake_q;

	assign tick_inc = tick_q + 32'd1;
	assign clr_inc  = (clr_q < cfg.leave_confirm) ? clr_q + 8'd1 : clr_q;
	assign line_inc = (line_q < cfg.finish_confirm) ? line_q + 8'd1 : line_q;

	// The result register may be refilled in the same cycle it is taken.
	assign q_pop = q_nonempty && (!out_valid_q || out_ready);

	always_comb begin
		tick_nxt = tick_q;
		run_nxt  = run_q;
		fin_nxt  = fin_q;
		left_nxt = left_q;
		clr_nxt  = clr_q;
		line_nxt = line_q;
		brake    = 1'b0;
		case (q_item.op)
			OP_START: begin
				tick_nxt = '0;
				run_nxt  = 1'b1;
				fin_nxt  = 1'b0;
				left_nxt = 1'b0;
				clr_nxt  = '0;
				line_nxt = '0;
			end
			OP_STOP: begin
				run_nxt = 1'b0;
			end
			OP_TICK: begin
				if (run_q) begin
					tick_nxt = tick_inc;
					if (!left_q) begin
						if (!q_item.line) begin
							clr_nxt = clr_inc;
							if (clr_inc >= cfg.leave_confirm) begin
								left_nxt = 1'b1;
								line_nxt = '0;
							end
						end else begin
							clr_nxt = '0;
						end
					end else if (tick_inc >= {16'd0, cfg.min_lap} && q_item.line) begin
						line_nxt = line_inc;
						if (line_inc >= cfg.finish_confirm) begin
							run_nxt = 1'b0;
							fin_nxt = 1'b1;
							brake   = 1'b1;
						end
					end else begin
						line_nxt = '0;
					end
				end
			end
			default: begin
				brake = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			run_q       <= 1'b0;
			fin_q       <= 1'b0;
			left_q      <= 1'b0;
			clr_q       <= '0;
			line_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				tick_q <= tick_nxt;
				run_q  <= run_nxt;
				fin_q  <= fin_nxt;
				left_q <= left_nxt;
				clr_q  <= clr_nxt;
				line_q <= line_nxt;
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ticks_q      <= tick_nxt;
			running_q    <= run_nxt;
			finished_q   <= fin_nxt;
			left_start_q <= left_nxt;
			brake_q      <= brake;
		end
	end

	assign out_valid      = out_valid_q;
	assign elapsed_ticks  = ticks_q;
	assign is_running     = running_q;
	assign is_finished    = finished_q;
	assign has_left_start = left_start_q;
	assign brake_request  = brake_q;

	`LTFD_ASSERT(a_brake_ends_lap, clk, arst_n, (out_valid_q && brake_q) |-> (finished_q && !running_q), "brake without a finished, halted lap")
	`LTFD_ASSERT(a_finish_needs_leave, clk, arst_n, fin_q |-> left_q, "finish confirmed before leaving start")
	`LTFD_ASSERT(a_run_excludes_finish, clk, arst_n, run_q |-> !fin_q, "running after finish")

endmodule

/* src/lap_timer_finish_line_detector.sv */
// Lap timer finish line detector, top level.
// Depends on ltfd_pkg, ltfd_front, ltfd_queue and ltfd_back.
//
// Input channel (in_valid/in_ready) takes one word per cycle while the queue
// has room: a command (tick, start, stop) and the line sensor bits. Every
// accepted word yields exactly one result word on the output channel
// (out_valid/out_ready) with the elapsed tick count and the running,
// finished, left-start and brake flags as they stand after that word.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and writes one of four registers; write it only while idle.
// The front decodes the command and counts set sensor bits against the
// threshold, then pushes the word into a two-entry queue. The back pops
// the queue, updates counters and flags, and loads the result register.
// An accepted word is stored in the queue, then popped into the result
// register behind out_valid, at one word per cycle while out_ready is high.
// When the receiver stalls, the result register holds, the queue fills,
// and in_ready drops once both queue entries are taken.
// Reset clears the lap state, empties the queue and restores the register
// defaults (leave 10, finish 3, minimum lap 1800, threshold 2).
module lap_timer_finish_line_detector #(
	parameter int unsigned SENSOR_COUNT = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ltfd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ltfd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       command,
	input  logic [SENSOR_COUNT-1:0]          line_sensors,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [31:0]                      elapsed_ticks,
	output logic                             is_running,
	output logic                             is_finished,
	output logic                             has_left_start,
	output logic                             brake_request
);
	import ltfd_pkg::*;

	cfg_t  cfg_q;
	logic  q_full, q_push, q_pop, q_nonempty;
	item_t push_item, head_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leave_confirm  <= LEAVE_CONFIRM_RESET;
			cfg_q.finish_confirm <= FINISH_CONFIRM_RESET;
			cfg_q.min_lap        <= MIN_LAP_RESET;
			cfg_q.threshold      <= THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LEAVE_CONFIRM:  cfg_q.leave_confirm  <= cfg_data[7:0];
				CFG_FINISH_CONFIRM: cfg_q.finish_confirm <= cfg_data[7:0];
				CFG_MIN_LAP:        cfg_q.min_lap        <= cfg_data;
				CFG_THRESHOLD:      cfg_q.threshold      <= cfg_data[2:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	ltfd_front #(
		.SENSOR_COUNT(SENSOR_COUNT)
	) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.line_sensors (line_sensors),
		.threshold    (cfg_q.threshold),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (push_item)
	);

	ltfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head_item (head_item)
	);

	ltfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_nonempty     (q_nonempty),
		.q_item         (head_item),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.elapsed_ticks  (elapsed_ticks),
		.is_running     (is_running),
		.is_finished    (is_finished),
		.has_left_start (has_left_start),
		.brake_request  (brake_request)
	);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lap_timer_finish_line_detector: an opening table of words,
// then random laps, checked by the table or a lap predictor. Needs ltfd_pkg and the RTL top.
module testbench;
	import ltfd_pkg::*;

	localparam int unsigned CLK_HALF = 4;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned RANDOM_WORDS = 550;
	localparam int unsigned PHASE_WORDS = 50;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 8'd9;

	// Field order: ticks, running, finished, left start, brake.
	typedef struct packed {
		logic [31:0] elapsed;
		logic        running;
		logic        finished;
		logic        left_start;
		logic        brake;
	} lap_result_t;

	typedef struct packed {
		bit          typed;
		lap_result_t want;
	} word_note_t;

	typedef struct {
		bit                     is_cfg;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0]  data;
		op_t                    op;
		logic [4:0]             sens;
		bit                     typed;
		lap_result_t            want;
	} opening_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [1:0]             command = OP_TICK;
	logic [4:0]             line_sensors = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [31:0]            elapsed_ticks;
	logic                   is_running;
	logic                   is_finished;
	logic                   has_left_start;
	logic                   brake_request;

	lap_timer_finish_line_detector #(.SENSOR_COUNT(5)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.line_sensors(line_sensors),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.elapsed_ticks(elapsed_ticks),
		.is_running(is_running),
		.is_finished(is_finished),
		.has_left_start(has_left_start),
		.brake_request(brake_request)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// Predicted lap state and its copy of the registers.
	logic [7:0]  p_leave;
	logic [7:0]  p_finish;
	logic [15:0] p_min_lap;
	logic [2:0]  p_thr;
	logic [31:0] lap_ticks;
	logic        lap_running;
	logic        lap_finished;
	logic        lap_left;
	logic [7:0]  clear_run;
	logic [7:0]  line_run;

	// Register values the stimulus generator steers by.
	int unsigned drv_leave;
	int unsigned drv_finish;
	int unsigned drv_min;
	int unsigned drv_thr;

	lap_result_t  lap_expect[$];
	word_note_t   word_notes[$];
	opening_row_t opening_rows[$];

	int unsigned words_sent = 0;
	int unsigned results_seen = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit          quiet = 1'b0;

	function automatic int unsigned count_set(logic [4:0] s);
		int unsigned n;
		n = 0;
		for (int i = 0; i < 5; i++)
			n += s[i];
		return n;
	endfunction

	function automatic lap_result_t advance_lap(op_t op, logic [4:0] sens);
		lap_result_t r;
		logic line;
		r.brake = 1'b0;
		line = (count_set(sens) >= p_thr);
		case (op)
		OP_START: begin
			lap_ticks = '0;
			lap_finished = 1'b0;
			lap_left = 1'b0;
			clear_run = '0;
			line_run = '0;
			lap_running = 1'b1;
		end
		OP_STOP: begin
			lap_running = 1'b0;
		end
		OP_TICK: begin
			if (lap_running) begin
				lap_ticks = lap_ticks + 32'd1;
				if (!lap_left) begin
					if (!line) begin
						if (clear_run < p_leave)
							clear_run = clear_run + 8'd1;
						if (clear_run >= p_leave) begin
							lap_left = 1'b1;
							line_run = '0;
						end
					end else begin
						clear_run = '0;
					end
				end else if (lap_ticks >= {16'd0, p_min_lap} && line) begin
					if (line_run < p_finish)
						line_run = line_run + 8'd1;
					if (line_run >= p_finish) begin
						lap_running = 1'b0;
						lap_finished = 1'b1;
						r.brake = 1'b1;
					end
				end else begin
					line_run = '0;
				end
			end
		end
		default: begin
		end
		endcase
		r.elapsed = lap_ticks;
		r.running = lap_running;
		r.finished = lap_finished;
		r.left_start = lap_left;
		return r;
	endfunction

	task automatic note_mismatch(string what, lap_result_t want, lap_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch (%0s) at cycle %0d: expected ticks %0d run %b fin %b left %b brake %b",
				what, cycle_count, want.elapsed, want.running, want.finished,
				want.left_start, want.brake);
		if (mismatch_count <= 10)
			$display("    got ticks %0d run %b fin %b left %b brake %b",
				got.elapsed, got.running, got.finished, got.left_start, got.brake);
	endtask

	always @(posedge clk) begin : check_results
		word_note_t  note;
		lap_result_t pred;
		lap_result_t got;
		lap_result_t want;
		if (!arst_n) begin
			p_leave = LEAVE_CONFIRM_RESET;
			p_finish = FINISH_CONFIRM_RESET;
			p_min_lap = MIN_LAP_RESET;
			p_thr = THRESHOLD_RESET;
			lap_ticks = '0;
			lap_running = 1'b0;
			lap_finished = 1'b0;
			lap_left = 1'b0;
			clear_run = '0;
			line_run = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_LEAVE_CONFIRM:  p_leave = cfg_data[7:0];
				CFG_FINISH_CONFIRM: p_finish = cfg_data[7:0];
				CFG_MIN_LAP:        p_min_lap = cfg_data[15:0];
				CFG_THRESHOLD:      p_thr = cfg_data[2:0];
				default: begin
				end
				endcase
			end
			if (in_valid && in_ready) begin
				note = word_notes.pop_front();
				pred = advance_lap(op_t'(command), line_sensors);
				lap_expect.push_back(note.typed ? note.want : pred);
			end
			if (out_valid && out_ready) begin
				got = {elapsed_ticks, is_running, is_finished, has_left_start, brake_request};
				results_seen++;
				if (lap_expect.size() == 0) begin
					note_mismatch("unexpected result", '0, got);
				end else begin
					want = lap_expect.pop_front();
					if (got !== want)
						note_mismatch("field", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: a fresh stall is drawn for every word taken.
	initial begin : result_sink
		int unsigned wait_cycles;
		@(posedge arst_n);
		forever begin
			wait_cycles = quiet ? 0 : $urandom_range(0, 14);
			if (wait_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_word(op_t op, logic [4:0] sens, bit typed, lap_result_t want);
		int unsigned gap;
		word_note_t note;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		note.typed = typed;
		note.want = want;
		word_notes.push_back(note);
		in_valid <= 1'b1;
		command <= op;
		line_sensors <= sens;
		words_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	// Always lets at least one edge pass, so valid is never lowered and raised in one step.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_seen != words_sent);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Unused upper data bits are filled with noise; the registers keep only their width.
	task automatic set_config(int unsigned leave, int unsigned fin, int unsigned min_lap,
			int unsigned thr);
		logic [7:0]  pad8;
		logic [12:0] pad13;
		drv_leave = leave;
		drv_finish = fin;
		drv_min = min_lap;
		drv_thr = thr;
		pad8 = 8'($urandom_range(0, 255));
		write_reg(CFG_LEAVE_CONFIRM, {pad8, leave[7:0]});
		pad8 = 8'($urandom_range(0, 255));
		write_reg(CFG_FINISH_CONFIRM, {pad8, fin[7:0]});
		write_reg(CFG_MIN_LAP, min_lap[15:0]);
		pad13 = 13'($urandom_range(0, 8191));
		write_reg(CFG_THRESHOLD, {pad13, thr[2:0]});
	endtask

	function automatic logic [4:0] pick_sensors(bit on_line);
		logic [4:0] s;
		s = 5'($urandom_range(0, 31));
		for (int k = 0; k < 40; k++) begin
			if ((count_set(s) >= drv_thr) == on_line)
				return s;
			s = 5'($urandom_range(0, 31));
		end
		return s;
	endfunction

	task automatic scatter_words(int unsigned n);
		for (int i = 0; i < n; i++)
			send_word(op_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), 1'b0, '0);
	endtask

	// One lap: start, clear ticks off the start line, filler up to the minimum lap time,
	// then line ticks for the finish, with the odd bounce, stop or idle word mixed in.
	task automatic run_lap();
		int unsigned ticks;
		int unsigned n;
		int unsigned i;
		int unsigned stretch;
		send_word(OP_START, 5'($urandom_range(0, 31)), 1'b0, '0);
		ticks = 0;
		n = drv_leave + $urandom_range(0, 2);
		i = 0;
		while (i < n) begin
			if ($urandom_range(0, 11) == 0) begin
				send_word(OP_TICK, pick_sensors(1'b1), 1'b0, '0);
				if (drv_leave <= 16)
					n += drv_leave;
			end else begin
				send_word(OP_TICK, pick_sensors(1'b0), 1'b0, '0);
			end
			ticks++;
			i++;
		end
		if ($urandom_range(0, 7) == 0)
			drain_results();
		stretch = 0;
		while (ticks < drv_min && stretch < 48) begin
			if ($urandom_range(0, 15) == 0) begin
				send_word(OP_NONE, 5'($urandom_range(0, 31)), 1'b0, '0);
			end else begin
				send_word(OP_TICK, 5'($urandom_range(0, 31)), 1'b0, '0);
				ticks++;
			end
			stretch++;
		end
		if ($urandom_range(0, 9) == 0) begin
			send_word(OP_STOP, 5'($urandom_range(0, 31)), 1'b0, '0);
			send_word(OP_TICK, 5'($urandom_range(0, 31)), 1'b0, '0);
		end else begin
			n = (drv_finish > 20 ? 20 : drv_finish) + $urandom_range(1, 3);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_word(OP_TICK, pick_sensors(1'b0), 1'b0, '0);
				else
					send_word(OP_TICK, pick_sensors(1'b1), 1'b0, '0);
			end
		end
	endtask

	function automatic void add_word(op_t op, logic [4:0] sens);
		opening_row_t r;
		r = '{is_cfg: 1'b0, idx: '0, data: '0, op: op, sens: sens, typed: 1'b0, want: '0};
		opening_rows.push_back(r);
	endfunction

	function automatic void add_checked(op_t op, logic [4:0] sens, lap_result_t want);
		opening_row_t r;
		r = '{is_cfg: 1'b0, idx: '0, data: '0, op: op, sens: sens, typed: 1'b1, want: want};
		opening_rows.push_back(r);
	endfunction

	function automatic void add_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		opening_row_t r;
		r = '{is_cfg: 1'b1, idx: idx, data: data, op: OP_TICK, sens: '0, typed: 1'b0, want: '0};
		opening_rows.push_back(r);
	endfunction

	initial begin : stimulus
		int unsigned random_start;
		int unsigned phase_start;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: leave 10, finish 3, minimum lap 1800, threshold 2.
		add_checked(OP_TICK,  5'b00000, {32'd0, 4'b0000});
		add_checked(OP_NONE,  5'b11111, {32'd0, 4'b0000});
		add_checked(OP_STOP,  5'b10101, {32'd0, 4'b0000});
		add_checked(OP_START, 5'b11111, {32'd0, 4'b1000});
		add_checked(OP_TICK,  5'b11111, {32'd1, 4'b1000});
		add_checked(OP_TICK,  5'b00001, {32'd2, 4'b1000});
		add_checked(OP_NONE,  5'b01010, {32'd2, 4'b1000});
		add_checked(OP_STOP,  5'b00000, {32'd2, 4'b0000});
		add_checked(OP_TICK,  5'b00000, {32'd2, 4'b0000});
		add_reg(CFG_LEAVE_CONFIRM, 16'hFF01);
		add_reg(CFG_FINISH_CONFIRM, 16'h0001);
		add_reg(CFG_MIN_LAP, 16'h0000);
		add_reg(CFG_THRESHOLD, 16'hFFF5);
		add_checked(OP_START, 5'b00000, {32'd0, 4'b1000});
		add_checked(OP_TICK,  5'b00000, {32'd1, 4'b1010});
		// Four of five bits set is still no line at threshold five.
		add_checked(OP_TICK,  5'b01111, {32'd2, 4'b1010});
		add_checked(OP_TICK,  5'b11111, {32'd3, 4'b0111});
		add_checked(OP_TICK,  5'b11111, {32'd3, 4'b0110});
		// A zero threshold sees the line on every tick, so the start is never left.
		add_reg(CFG_THRESHOLD, 16'h0000);
		add_checked(OP_START, 5'b11111, {32'd0, 4'b1000});
		add_checked(OP_TICK,  5'b00000, {32'd1, 4'b1000});
		// Zero confirm counts act on the first qualifying tick; threshold seven sees nothing.
		add_reg(CFG_LEAVE_CONFIRM, 16'h0000);
		add_reg(CFG_FINISH_CONFIRM, 16'h0000);
		add_reg(CFG_THRESHOLD, 16'h0007);
		add_checked(OP_TICK,  5'b11111, {32'd2, 4'b1010});
		add_reg(CFG_THRESHOLD, 16'h0001);
		add_checked(OP_TICK,  5'b10000, {32'd3, 4'b0111});
		add_reg(CFG_LEAVE_CONFIRM, 16'h00FF);
		add_reg(CFG_FINISH_CONFIRM, 16'h00FF);
		add_reg(CFG_MIN_LAP, 16'hFFFF);
		add_reg(CFG_THRESHOLD, 16'h0006);
		add_reg(CFG_UNMAPPED, 16'h1234);
		add_word(OP_START, 5'b01100);
		add_word(OP_TICK, 5'b11111);
		add_word(OP_STOP, 5'b00011);

		foreach (opening_rows[i]) begin
			if (opening_rows[i].is_cfg)
				write_reg(opening_rows[i].idx, opening_rows[i].data);
			else
				send_word(opening_rows[i].op, opening_rows[i].sens, opening_rows[i].typed,
					opening_rows[i].want);
		end

		random_start = words_sent;
		for (int k = 0; k < 6 || words_sent - random_start < RANDOM_WORDS; k++) begin
			quiet = (k % 3 == 2);
			case (k)
			0: set_config(1, 1, 0, 1);
			1: set_config(255, 255, 65535, 5);
			2: set_config(0, 0, $urandom_range(0, 20), 0);
			3: set_config(0, 0, $urandom_range(0, 20), 6);
			4: set_config($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(0, 30), 3);
			5: set_config($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(0, 30), 4);
			default: set_config($urandom_range(1, 12), $urandom_range(1, 6),
				$urandom_range(0, 40), $urandom_range(1, 5));
			endcase
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS) begin
				if ($urandom_range(0, 4) == 0)
					scatter_words($urandom_range(1, 6));
				else
					run_lap();
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatch_count += lap_expect.size();
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* lap_timer_finish_line_detector.f */
+incdir+src
src/ltfd_pkg.sv
src/ltfd_front.sv
src/ltfd_queue.sv
src/ltfd_back.sv
src/lap_timer_finish_line_detector.sv
tb/testbench.sv
